### sv/binomial_american_option_pricer_unit_defines.svh
`ifndef BINOMIAL_AMERICAN_OPTION_PRICER_UNIT_DEFINES_SVH
`define BINOMIAL_AMERICAN_OPTION_PRICER_UNIT_DEFINES_SVH

// same-cycle implication
`define BAP_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m failed");

// next-cycle implication
`define BAP_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("%m failed");

`endif

### sv/bap_pkg.sv
package bap_pkg;

   localparam int MAX_STEPS = 256;
   localparam int DEPTH     = MAX_STEPS + 1;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);

   localparam logic [2:0] REG_UP_FACTOR  = 3'd0;
   localparam logic [2:0] REG_DOWN       = 3'd1;
   localparam logic [2:0] REG_UP_PROB    = 3'd2;
   localparam logic [2:0] REG_DISCOUNT   = 3'd3;
   localparam logic [2:0] REG_IS_CALL    = 3'd4;
   localparam logic [2:0] REG_STEPS      = 3'd5;

   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] under;
   } node_type;

   typedef struct packed {
      logic pop;
      logic push;
   } chain_ctl_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] v_up;
      logic [31:0] v_dn;
      logic [31:0] under;
   } pe_in_type;

   typedef struct packed {
      logic        valid;
      logic        sat;
      node_type    node;
   } pe_out_type;

   // {sat, value}: Q2.30 product rounded half up and clipped
   function automatic logic [32:0] rnd30(input logic [63:0] prod);
      logic [64:0] t;
      logic        s;
      t = {1'b0, prod} + 65'(64'd1 << 29);
      s = |t[64:62];
      return {s, s ? 32'hFFFF_FFFF : t[61:30]};
   endfunction

   function automatic logic [32:0] rnd31(input logic [63:0] prod);
      logic [64:0] t;
      logic        s;
      t = {1'b0, prod} + 65'(64'd1 << 30);
      s = |t[64:63];
      return {s, s ? 32'hFFFF_FFFF : t[62:31]};
   endfunction

   function automatic logic [31:0] exercise(input logic [31:0] s, input logic [31:0] k,
                                            input logic call);
      logic [31:0] r;
      if (call) begin
         r = (s > k) ? s - k : 32'd0;
      end else begin
         r = (k > s) ? k - s : 32'd0;
      end
      return r;
   endfunction

endpackage

### sv/bap_cell.sv
module bap_cell (
   input  logic              clock,
   input  logic              shift,
   input  logic              load,
   input  bap_pkg::node_type nbr,
   input  bap_pkg::node_type wdata,
   output bap_pkg::node_type q
);
   import bap_pkg::*;

   node_type node_ff;
   node_type node_in;

   always_comb begin
      node_in = node_ff;
      if (load) begin
         node_in = wdata;
      end else if (shift) begin
         node_in = nbr;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign q = node_ff;
endmodule

### sv/bap_chain.sv
module bap_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  bap_pkg::chain_ctl_type ctl,
   input  bap_pkg::node_type     wdata,
   output bap_pkg::node_type     head
);
   import bap_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] wpos;
   node_type         q_arr [DEPTH];

   assign wpos = ctl.pop ? count_ff - CNT_W'(1) : count_ff;

   always_comb begin
      count_in = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!ctl.push && ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      node_type nbr;
      if (g < DEPTH - 1) begin : g_mid
         assign nbr = q_arr[g+1];
      end else begin : g_end
         assign nbr = wdata;
      end
      bap_cell u_cell (
         .clock (clock),
         .shift (ctl.pop),
         .load  (ctl.push && (wpos == CNT_W'(g))),
         .nbr   (nbr),
         .wdata (wdata),
         .q     (q_arr[g])
      );
   end

   assign head = q_arr[0];
endmodule

### sv/bap_pe.sv
module bap_pe (
   input  logic                clock,
   input  logic                reset,
   input  bap_pkg::pe_in_type  pin,
   input  logic [31:0]         p_use,
   input  logic [31:0]         q_use,
   input  logic [31:0]         discount,
   input  logic [30:0]         down,
   input  logic [31:0]         strike,
   input  logic                is_call,
   output bap_pkg::pe_out_type pout,
   output logic                busy
);
   import bap_pkg::*;

   logic [2:0]  vld_ff;
   logic [63:0] m_up_ff, m_dn_ff, m_u_ff;
   logic [31:0] exp_ff, und2_ff;
   logic        sat2_ff;
   logic [63:0] held_ff;
   logic [31:0] ex3_ff, und3_ff;
   logic        sat3_ff;
   pe_out_type  out_ff;

   logic [63:0] acc;
   logic [64:0] acc_r;
   logic [32:0] und_r;
   logic [32:0] held_r;

   assign acc    = m_up_ff + m_dn_ff;
   assign acc_r  = {1'b0, acc} + 65'(64'd1 << 30);
   assign und_r  = rnd30(m_u_ff);
   assign held_r = rnd31(held_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_ff.valid <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[1:0], pin.valid};
         out_ff.valid <= vld_ff[2];
      end
      m_up_ff  <= {32'd0, p_use} * {32'd0, pin.v_up};
      m_dn_ff  <= {32'd0, q_use} * {32'd0, pin.v_dn};
      m_u_ff   <= {32'd0, pin.under} * {33'd0, down};
      exp_ff   <= acc_r[62:31];
      und2_ff  <= und_r[31:0];
      sat2_ff  <= und_r[32];
      held_ff  <= {32'd0, exp_ff} * {32'd0, discount};
      ex3_ff   <= exercise(und2_ff, strike, is_call);
      und3_ff  <= und2_ff;
      sat3_ff  <= sat2_ff;
      out_ff.sat        <= sat3_ff | held_r[32];
      out_ff.node.value <= (held_r[31:0] > ex3_ff) ? held_r[31:0] : ex3_ff;
      out_ff.node.under <= und3_ff;
   end

   assign pout = out_ff;
   assign busy = (|vld_ff) | out_ff.valid;
endmodule

### sv/binomial_american_option_pricer_unit.sv
// Throughput: one request at a time; the next is taken once the previous
// result sits in the output register. Within a level, rollback pops one
// node per cycle from the cell chain through a single 4-stage node-update
// pipeline, then waits for the pipeline to drain before the next level.
// Reset (synchronous): state and settings return to defaults; chain emptied.
`include "binomial_american_option_pricer_unit_defines.svh"
module binomial_american_option_pricer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_strike_price,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_option_value,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import bap_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_UP, S_TERM, S_ROLL, S_DRAIN, S_DONE} state_type;

   state_type          state_ff;
   logic [31:0]        up_ff, prob_ff, disc_ff;
   logic [30:0]        dn_ff;
   logic               call_ff;
   logic [8:0]         steps_ff;
   logic [31:0]        strike_ff, s_ff, p_use_ff, q_use_ff;
   logic [63:0]        prod_ff;
   logic               sat_ff;
   logic [1:0]         ph_ff;
   logic [STEP_W-1:0]  n_ff, cnt_ff, lvl_ff;
   logic [CNT_W-1:0]   pop_ff;
   node_type           prev_ff;
   logic               rsp_valid_ff, rsp_sat_ff;
   logic [31:0]        rsp_value_ff;

   logic [31:0]        fac;
   logic [32:0]        s_r;
   logic [STEP_W-1:0]  n_clamp;
   logic [31:0]        p_clamp;
   chain_ctl_type      ctl;
   node_type           wdata, head;
   pe_in_type          pin;
   pe_out_type         pout;
   logic               pe_busy;

   assign fac     = (state_ff == S_UP) ? up_ff : {1'b0, dn_ff};
   assign s_r     = rnd30(prod_ff);
   assign p_clamp = (prob_ff > ONE_Q31) ? ONE_Q31 : prob_ff;
   assign n_clamp = (steps_ff == 9'd0) ? STEP_W'(1) :
                    (steps_ff > 9'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : STEP_W'(steps_ff);

   always_comb begin
      ctl.push = pout.valid;
      wdata    = pout.node;
      if (state_ff == S_TERM && ph_ff == 2'd0) begin
         ctl.push    = 1'b1;
         wdata.under = s_ff;
         wdata.value = exercise(s_ff, strike_ff, call_ff);
      end
      ctl.pop = (state_ff == S_ROLL) ||
                (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall));
      pin.valid = (state_ff == S_ROLL) && (pop_ff != '0);
      pin.v_up  = prev_ff.value;
      pin.v_dn  = head.value;
      pin.under = prev_ff.under;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         up_ff        <= 32'h4000_0000;
         dn_ff        <= 31'h4000_0000;
         prob_ff      <= 32'h4000_0000;
         disc_ff      <= 32'h8000_0000;
         call_ff      <= 1'b1;
         steps_ff     <= 9'd1;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_UP_FACTOR: up_ff    <= csr_wdata;
               REG_DOWN:      dn_ff    <= csr_wdata[30:0];
               REG_UP_PROB:   prob_ff  <= csr_wdata;
               REG_DISCOUNT:  disc_ff  <= csr_wdata;
               REG_IS_CALL:   call_ff  <= csr_wdata[0];
               REG_STEPS:     steps_ff <= csr_wdata[8:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pout.valid) begin
            sat_ff <= sat_ff | pout.sat;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  s_ff      <= req_spot_price;
                  strike_ff <= req_strike_price;
                  n_ff      <= n_clamp;
                  cnt_ff    <= n_clamp;
                  p_use_ff  <= p_clamp;
                  q_use_ff  <= ONE_Q31 - p_clamp;
                  sat_ff    <= 1'b0;
                  ph_ff     <= 2'd0;
                  state_ff  <= S_UP;
               end
            end
            S_UP: begin
               if (ph_ff[0] == 1'b0) begin
                  prod_ff <= {32'd0, s_ff} * {32'd0, fac};
                  ph_ff   <= 2'd1;
               end else begin
                  s_ff   <= s_r[31:0];
                  sat_ff <= sat_ff | s_r[32];
                  ph_ff  <= 2'd0;
                  cnt_ff <= cnt_ff - STEP_W'(1);
                  if (cnt_ff == STEP_W'(1)) begin
                     state_ff <= S_TERM;
                  end
               end
            end
            S_TERM: begin
               ph_ff <= ph_ff + 2'd1;
               if (ph_ff[0] == 1'b0) begin
                  prod_ff <= {32'd0, s_ff} * {32'd0, fac};
               end else begin
                  s_ff   <= s_r[31:0];
                  sat_ff <= sat_ff | s_r[32];
                  if (ph_ff == 2'd3) begin
                     if (cnt_ff == n_ff) begin
                        lvl_ff   <= n_ff - STEP_W'(1);
                        pop_ff   <= '0;
                        state_ff <= S_ROLL;
                     end else begin
                        cnt_ff <= cnt_ff + STEP_W'(1);
                     end
                  end
               end
            end
            S_ROLL: begin
               prev_ff <= head;
               pop_ff  <= pop_ff + CNT_W'(1);
               if (pop_ff == CNT_W'(lvl_ff) + CNT_W'(1)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!pe_busy) begin
                  pop_ff <= '0;
                  if (lvl_ff == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     lvl_ff   <= lvl_ff - STEP_W'(1);
                     state_ff <= S_ROLL;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= head.value;
                  rsp_sat_ff   <= sat_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   bap_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .wdata (wdata),
      .head  (head)
   );

   bap_pe u_pe (
      .clock    (clock),
      .reset    (reset),
      .pin      (pin),
      .p_use    (p_use_ff),
      .q_use    (q_use_ff),
      .discount (disc_ff),
      .down     (dn_ff),
      .strike   (strike_ff),
      .is_call  (call_ff),
      .pout     (pout),
      .busy     (pe_busy)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_option_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   `BAP_ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_valid && !req_stall, state_ff == S_UP)
   `BAP_ASSERT_NOW(a_pe_push_in_roll, clock, reset, pout.valid,
      state_ff == S_ROLL || state_ff == S_DRAIN)
   `BAP_ASSERT_NOW(a_done_pe_idle, clock, reset, state_ff == S_DONE, !pe_busy)
endmodule

### bench/binomial_american_option_pricer_checker.sv
`timescale 1ns / 1ps
module binomial_american_option_pricer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_strike_price,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_option_value,
   input  logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import bap_pkg::*;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } quote_type;

   logic [31:0] cfg_up;
   logic [30:0] cfg_down;
   logic [31:0] cfg_prob;
   logic [31:0] cfg_disc;
   logic        cfg_call;
   logic [8:0]  cfg_steps;

   logic [31:0] tree_value [0:MAX_STEPS];
   logic [31:0] tree_under [0:MAX_STEPS];

   quote_type quote_q[$];

   function automatic logic [31:0] scale(input logic [31:0] a, input logic [31:0] b,
                                         input int sh, inout logic sat);
      logic [64:0] t;
      t = {1'b0, 64'(a) * 64'(b)} + (65'd1 << (sh - 1));
      t = t >> sh;
      if (t[64:32] != '0) begin
         sat = 1'b1;
         return 32'hFFFF_FFFF;
      end
      return t[31:0];
   endfunction

   function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] k);
      if (cfg_call) return (s > k) ? s - k : 32'd0;
      return (k > s) ? k - s : 32'd0;
   endfunction

   function automatic quote_type price_option(input logic [31:0] spot,
                                              input logic [31:0] strike);
      int          n;
      logic [31:0] p;
      logic [31:0] q;
      logic [31:0] s;
      logic [31:0] held;
      logic [31:0] und;
      logic [31:0] ex;
      logic [63:0] acc;
      logic [64:0] wide;
      logic        sat;
      quote_type   r;
      n = cfg_steps;
      if (n == 0) n = 1;
      if (n > MAX_STEPS) n = MAX_STEPS;
      p = (cfg_prob > ONE_Q31) ? ONE_Q31 : cfg_prob;
      q = ONE_Q31 - p;
      sat = 1'b0;
      s = spot;
      for (int i = 0; i < n; i++) s = scale(s, cfg_up, 30, sat);
      for (int j = 0; j <= n; j++) begin
         tree_under[j] = s;
         tree_value[j] = payoff(s, strike);
         s = scale(s, {1'b0, cfg_down}, 30, sat);
         s = scale(s, {1'b0, cfg_down}, 30, sat);
      end
      for (int i = n - 1; i >= 0; i--) begin
         for (int j = 0; j <= i; j++) begin
            acc = 64'(p) * 64'(tree_value[j]) + 64'(q) * 64'(tree_value[j + 1]);
            wide = {1'b0, acc} + (65'd1 << 30);
            held = scale(wide[62:31], cfg_disc, 31, sat);
            und = scale(tree_under[j], {1'b0, cfg_down}, 30, sat);
            ex = payoff(und, strike);
            tree_under[j] = und;
            tree_value[j] = (held > ex) ? held : ex;
         end
      end
      r.value = tree_value[0];
      r.sat = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      quote_type exp_q;
      if (reset) begin
         cfg_up    <= 32'h4000_0000;
         cfg_down  <= 31'h4000_0000;
         cfg_prob  <= 32'h4000_0000;
         cfg_disc  <= ONE_Q31;
         cfg_call  <= 1'b1;
         cfg_steps <= 9'd1;
         quote_q.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_UP_FACTOR: cfg_up <= csr_wdata;
               REG_DOWN:      cfg_down <= csr_wdata[30:0];
               REG_UP_PROB:   cfg_prob <= csr_wdata;
               REG_DISCOUNT:  cfg_disc <= csr_wdata;
               REG_IS_CALL:   cfg_call <= csr_wdata[0];
               REG_STEPS:     cfg_steps <= csr_wdata[8:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            quote_q.push_back(price_option(req_spot_price, req_strike_price));
         if (rsp_valid && !rsp_stall) begin
            if (quote_q.size() == 0) begin
               $display("%0t: unexpected result value=%h sat=%b", $time,
                        rsp_option_value, rsp_saturated);
               fail_count++;
            end else begin
               exp_q = quote_q.pop_front();
               if (rsp_option_value !== exp_q.value) begin
                  $display("%0t: option_value expected %h actual %h", $time,
                           exp_q.value, rsp_option_value);
                  fail_count++;
               end
               if (rsp_saturated !== exp_q.sat) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           exp_q.sat, rsp_saturated);
                  fail_count++;
               end
            end
         end
         pending = quote_q.size();
      end
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
   import bap_pkg::*;

   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;
   localparam logic [31:0] PRICE_100 = 32'd100 << 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_spot_price = '0;
   logic [31:0] req_strike_price = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_option_value;
   logic        rsp_saturated;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          burst_left = 0;
   int          hold_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binomial_american_option_pricer_unit u_dut (.*);

   binomial_american_option_pricer_checker u_chk (.*);

   initial begin
      #200ms;
      $display("FAIL binomial_american_option_pricer_unit");
      $finish;
   end

   // receiver: changing stall pattern, plus a long hold when asked
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(8, 80);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic send_request(input logic [31:0] spot, input logic [31:0] strike);
      req_valid <= 1'b1;
      req_spot_price <= spot;
      req_strike_price <= strike;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         burst_left = $urandom_range(0, 8);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_regs(input logic [31:0] up, input logic [31:0] down,
                             input logic [31:0] prob, input logic [31:0] disc,
                             input logic [31:0] call, input logic [31:0] steps);
      logic [2:0]  idx [6];
      logic [31:0] val [6];
      idx = '{REG_UP_FACTOR, REG_DOWN, REG_UP_PROB, REG_DISCOUNT, REG_IS_CALL, REG_STEPS};
      val = '{up, down, prob, disc, call, steps};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] near_price();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return PRICE_100 + $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
   endfunction

   initial begin
      logic [31:0] up;
      logic [31:0] n;
      int          count;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults, price extremes
      send_request(32'h0, 32'h0);
      send_request(32'hFFFF_FFFF, 32'h0);
      send_request(32'h0, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(PRICE_100, 32'd90 << 16);
      drain();

      // realistic tree, call then put
      up = 32'h4000_0000 + 32'h0050_0000;
      write_regs(up, 32'((64'd1 << 60) / up), 32'h4100_0000, 32'h7FFF_0000, 1, 16);
      send_request(PRICE_100, PRICE_100);
      send_request(PRICE_100, 32'd120 << 16);
      drain();
      write_regs(up, 32'((64'd1 << 60) / up), 32'h4100_0000, 32'h7FF0_0000, 0, 16);
      send_request(PRICE_100, PRICE_100);
      send_request(PRICE_100, 32'd130 << 16);
      send_request(32'd40 << 16, PRICE_100);
      drain();

      // saturating factors, probability above one, zero step count
      write_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
      csr_we <= 1'b1;
      csr_index <= REG_SPARE_LO;
      csr_wdata <= 32'hFFFF_FFFF;
      @(negedge clock);
      csr_index <= REG_SPARE_HI;
      @(negedge clock);
      csr_we <= 1'b0;
      send_request(PRICE_100, 32'd1 << 16);
      send_request(32'hFFFF_FFFF, 32'h0);
      drain();

      // zero down factor, probability and discount, step count above the maximum
      write_regs(32'h4000_0000, 32'h0, 32'h0, 32'h0, 0, 511);
      send_request(PRICE_100, 32'd110 << 16);
      drain();

      // full-depth tree
      up = 32'h4000_0000 + 32'h0008_0000;
      write_regs(up, 32'((64'd1 << 60) / up), 32'h4080_0000, 32'h7FFF_F000, 0, MAX_STEPS);
      send_request(PRICE_100, 32'd105 << 16);
      drain();

      // receiver held off for a long stretch while requests keep coming
      up = 32'h4000_0000 + 32'h0050_0000;
      write_regs(up, 32'((64'd1 << 60) / up), 32'h4100_0000, 32'h7FFF_0000, 1, 4);
      hold_cycles = 3000;
      send_request(PRICE_100, 32'd95 << 16);
      send_request(PRICE_100, 32'd100 << 16);
      send_request(PRICE_100, 32'd105 << 16);
      send_request(PRICE_100, 32'd110 << 16);
      drain();

      count = 0;
      for (int ph = 0; count < 85; ph++) begin
         if ($urandom_range(0, 3) == 0) begin
            n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : $urandom & 32'h1FF;
            write_regs($urandom, $urandom, $urandom, $urandom, $urandom, n);
         end else begin
            up = 32'h4000_0000 + $urandom_range(0, 32'h0200_0000);
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(100, MAX_STEPS)
                                             : $urandom_range(1, 12);
            write_regs(up, 32'((64'd1 << 60) / up), $urandom_range(0, 32'h8000_0000),
                       32'h8000_0000 - $urandom_range(0, 32'h0100_0000),
                       $urandom_range(0, 1), n);
         end
         if (ph == 2) hold_cycles = 3000;
         for (int k = ((n[8:0] > 12 || n[8:0] == 0 && 0) ? 11 : 0); k < 12
              && count < 85; k++) begin
            if (ph == 4 && k == 3) drain();
            send_request(near_price(), near_price());
            count++;
            if (n[8:0] > 12) break;
            if ($urandom_range(0, 5) == 0) break;
         end
         drain();
      end

      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS binomial_american_option_pricer_unit");
      end else begin
         $display("FAIL binomial_american_option_pricer_unit");
      end
      $finish;
   end

endmodule
